// ===== sv/numeric_range_criteria_counter_core_macros.svh =====
// Assertion macros shared by the counter RTL.
`ifndef NUMERIC_RANGE_CRITERIA_COUNTER_CORE_MACROS_SVH
`define NUMERIC_RANGE_CRITERIA_COUNTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked while out of reset.
`define NRCC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("nrcc assertion failed");

// Implication whose consequent is checked in the cycle after its condition.
`define NRCC_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("nrcc assertion failed");

`else

`define NRCC_ASSERT(name, clk, rst_n, prop)
`define NRCC_ASSERT_NEXT(name, clk, rst_n, cond, prop)

`endif

`endif

// ===== sv/nrcc_pkg.sv =====
package nrcc_pkg;

	localparam int NUM_RANGES  = 7;
	localparam int VALUE_WIDTH = 32;

	localparam int RANGE_SLOTS = 7;
	localparam int BOUND_W     = 32;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int MODE_W      = 2;
	localparam int COUNT_W     = 16;
	localparam int SLOT_IDX_W  = $clog2(RANGE_SLOTS);

	localparam logic [CFG_IDX_W-1:0] REG_MISSING_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_BASE   = CFG_IDX_W'(1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Reset value of a range register: low 1, high 0, so disabled.
	localparam logic [CFG_DATA_W-1:0] RANGE_RESET = CFG_DATA_W'(64'h0000_0001_0000_0000);

	typedef struct packed {
		logic signed [BOUND_W-1:0] lo;
		logic signed [BOUND_W-1:0] hi;
	} range_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               is_sysmis;
		logic               is_user_missing;
		logic               last_value;
	} item_t;

endpackage

// ===== sv/nrcc_match.sv =====
module nrcc_match (
	input  logic [nrcc_pkg::MODE_W-1:0] missing_mode,
	input  nrcc_pkg::range_t            ranges [nrcc_pkg::RANGE_SLOTS],
	input  nrcc_pkg::item_t             item,
	output logic                        hit
);

	logic signed [nrcc_pkg::VALUE_WIDTH-1:0] value;
	logic signed [nrcc_pkg::BOUND_W-1:0]     value_x;
	logic [nrcc_pkg::NUM_RANGES-1:0]         in_range;

	// Only the low value bits carry the number; sign-extend them to bound width.
	assign value   = item.sample[nrcc_pkg::VALUE_WIDTH-1:0];
	assign value_x = nrcc_pkg::BOUND_W'(value);

	always_comb begin
		for (int i = 0; i < nrcc_pkg::NUM_RANGES; i++) begin
			in_range[i] = (ranges[i].lo <= ranges[i].hi) &&
				(value_x >= ranges[i].lo) && (value_x <= ranges[i].hi);
		end
	end

	always_comb begin
		priority if (item.is_sysmis) begin
			hit = (missing_mode != '0);
		end else if (item.is_user_missing && missing_mode[1]) begin
			hit = 1'b1;
		end else begin
			hit = |in_range;
		end
	end

endmodule

// ===== sv/numeric_range_criteria_counter_core.sv =====
// Counts the values of a record that meet a set of inclusive numeric ranges, with
// system-missing and user-missing handling set by missing_mode, and emits the
// saturated 16-bit count on the beat that carries last_value. One value is taken
// every cycle: a beat is registered, matched against all ranges in parallel and
// added to the running count in the next cycle; a record's count is registered in
// count_s2 and shown on match_count once its last beat leaves the input register.
// Only a last beat can wait, and only while the previous count is still held by a
// stalled output. The user writes configuration (missing_mode, range_0..range_6)
// via wr_en/wr_index/wr_data only while no record is in flight; nothing enforces it.
`include "numeric_range_criteria_counter_core_macros.svh"

module numeric_range_criteria_counter_core (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              wr_en,
	input  logic [nrcc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [nrcc_pkg::CFG_DATA_W-1:0]   wr_data,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [31:0]                sample,
	input  logic                              is_sysmis,
	input  logic                              is_user_missing,
	input  logic                              last_value,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [nrcc_pkg::COUNT_W-1:0]      match_count
);

	logic [nrcc_pkg::MODE_W-1:0]  mode_q;
	nrcc_pkg::range_t             ranges_q [nrcc_pkg::RANGE_SLOTS];
	logic [nrcc_pkg::CFG_IDX_W-1:0] slot_sel;

	logic                         valid_s1;
	nrcc_pkg::item_t              item_s1;
	logic                         valid_s2;
	logic [nrcc_pkg::COUNT_W-1:0] count_s2;
	logic [nrcc_pkg::COUNT_W-1:0] count_q;
	logic [nrcc_pkg::COUNT_W-1:0] total;
	logic                         hit;
	logic                         adv_s1;
	logic                         out_free;

	assign slot_sel = wr_index - nrcc_pkg::REG_RANGE_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			for (int i = 0; i < nrcc_pkg::RANGE_SLOTS; i++) begin
				ranges_q[i] <= nrcc_pkg::RANGE_RESET;
			end
		end else if (wr_en) begin
			if (wr_index == nrcc_pkg::REG_MISSING_MODE) begin
				mode_q <= wr_data[nrcc_pkg::MODE_W-1:0];
			end else if (slot_sel < nrcc_pkg::CFG_IDX_W'(nrcc_pkg::RANGE_SLOTS)) begin
				ranges_q[slot_sel[nrcc_pkg::SLOT_IDX_W-1:0]] <= wr_data;
			end
		end
	end

	nrcc_match u_match (
		.missing_mode (mode_q),
		.ranges       (ranges_q),
		.item         (item_s1),
		.hit          (hit)
	);

	// A beat without last_value leaves no result and never waits on the output.
	assign out_free = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && (!item_s1.last_value || out_free);
	assign in_stall = valid_s1 && !adv_s1;

	assign total = count_q + nrcc_pkg::COUNT_W'(hit && (count_q != nrcc_pkg::COUNT_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			count_q  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			if (adv_s1) begin
				count_q <= item_s1.last_value ? '0 : total;
			end

			if (adv_s1 && item_s1.last_value) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{sample, is_sysmis, is_user_missing, last_value};
		end
		if (adv_s1 && item_s1.last_value) begin
			count_s2 <= total;
		end
	end

	assign out_valid   = valid_s2;
	assign match_count = count_s2;

	`NRCC_ASSERT(a_stall_needs_item, clk, arst_n, in_stall |-> (valid_s1 && item_s1.last_value))
	`NRCC_ASSERT_NEXT(a_clear_on_last, clk, arst_n, adv_s1 && item_s1.last_value, count_q == '0)
	`NRCC_ASSERT_NEXT(a_count_step, clk, arst_n, adv_s1 && !item_s1.last_value,
		(count_q == $past(count_q)) || (count_q == $past(count_q) + nrcc_pkg::COUNT_W'(1)))
	`NRCC_ASSERT_NEXT(a_count_idle, clk, arst_n, !adv_s1, $stable(count_q))

endmodule
